// File: rtl/tsr_pkg.sv
// Shared constants, codes and control types of the TCP segment reorder table.
package tsr_pkg;

  // Table geometry
  localparam int MAX_SEGMENTS = 64;
  localparam int SEG_ADDR_W   = $clog2(MAX_SEGMENTS);
  localparam int COUNT_W      = $clog2(MAX_SEGMENTS + 1);

  // Field widths
  localparam int ACTION_W      = 2;
  localparam int SEQ_W         = 32;
  localparam int LEN_W         = 16;
  localparam int STATUS_W      = 4;
  localparam int OUT_COUNT_W   = 7;
  localparam int BYTES_W       = 22;
  localparam int ENTRY_W       = SEQ_W + LEN_W;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_MAX_LEN = '0;

  localparam logic [LEN_W-1:0]   RESET_MAX_LEN = LEN_W'(64000);
  localparam logic [BYTES_W-1:0] BYTES_MAX     = '1;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CHECK  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 4'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 4'd1;
  localparam logic [STATUS_W-1:0] ST_WRAP      = 4'd2;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 4'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 4'd4;
  localparam logic [STATUS_W-1:0] ST_OVERLAP   = 4'd5;
  localparam logic [STATUS_W-1:0] ST_GAPS      = 4'd6;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 4'd7;
  localparam logic [STATUS_W-1:0] ST_OK        = 4'd8;

  // Commands from controller to datapath
  typedef struct packed {
    logic                  load;
    logic                  mem_rd;
    logic                  mem_we;
    logic                  wr_shift;
    logic [SEG_ADDR_W-1:0] addr;
    logic                  prev_load;
    logic                  commit;
    logic                  clear;
    logic                  set_status;
    logic [STATUS_W-1:0]   status;
  } tsr_cmd_t;

  // Flags from datapath to controller
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                len_bad;
    logic                full;
    logic                wrap;
    logic [COUNT_W-1:0]  count;
    logic                eq;
    logic                lt;
    logic                lt_over;
    logic                gt_over;
    logic                gap;
  } tsr_sts_t;

endpackage

// File: rtl/tsr_if.sv
// Item channels: segment request in, status result out.
interface tsr_req_if;
  import tsr_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SEQ_W-1:0]    seq_start;
  logic [LEN_W-1:0]    seg_length;
  modport source (output valid, action, seq_start, seg_length, input ready);
  modport sink   (input valid, action, seq_start, seg_length, output ready);
endinterface

interface tsr_res_if;
  import tsr_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [OUT_COUNT_W-1:0] segment_count;
  logic [BYTES_W-1:0]     byte_total;
  modport source (output valid, status, segment_count, byte_total, input ready);
  modport sink   (input valid, status, segment_count, byte_total, output ready);
endinterface

// File: rtl/tsr_regs.sv
// APB-style configuration register holding the maximum segment length.
module tsr_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tsr_pkg::PADDR_W-1:0]   paddr,
  input  logic [tsr_pkg::PDATA_W-1:0]   pwdata,
  output logic [tsr_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [tsr_pkg::LEN_W-1:0]     max_len
);
  import tsr_pkg::*;

  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[PADDR_W-1:2] == REG_MAX_LEN);

  // Write the register in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= RESET_MAX_LEN;
    end else if (psel && penable && pwrite && hit) begin
      max_len <= pwdata[LEN_W-1:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = PDATA_W'(max_len);
    end
  end
endmodule

// File: rtl/tsr_dp.sv
// Datapath: segment table memory, held item, count, byte total and compares.
module tsr_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  tsr_pkg::tsr_cmd_t             cmd,
  output tsr_pkg::tsr_sts_t             sts,
  input  logic [tsr_pkg::ACTION_W-1:0]  in_action,
  input  logic [tsr_pkg::SEQ_W-1:0]     in_seq,
  input  logic [tsr_pkg::LEN_W-1:0]     in_len,
  input  logic [tsr_pkg::LEN_W-1:0]     max_len,
  output logic [tsr_pkg::STATUS_W-1:0]  status,
  output logic [tsr_pkg::COUNT_W-1:0]   count,
  output logic [tsr_pkg::BYTES_W-1:0]   bytes
);
  import tsr_pkg::*;

  logic [ENTRY_W-1:0]  mem [MAX_SEGMENTS];
  logic [ENTRY_W-1:0]  rd_data;
  logic [ACTION_W-1:0] act_q;
  logic [SEQ_W-1:0]    seq_q;
  logic [LEN_W-1:0]    len_q;
  logic [SEQ_W:0]      new_end;
  logic [SEQ_W:0]      prev_end;
  logic [SEQ_W-1:0]    rd_start;
  logic [LEN_W-1:0]    rd_len;
  logic [SEQ_W:0]      rd_end;
  logic [BYTES_W:0]    bytes_sum;

  assign rd_start  = rd_data[ENTRY_W-1:LEN_W];
  assign rd_len    = rd_data[LEN_W-1:0];
  assign rd_end    = {1'b0, rd_start} + (SEQ_W+1)'(rd_len);
  assign bytes_sum = {1'b0, bytes} + (BYTES_W+1)'(len_q);

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q   <= in_action;
      seq_q   <= in_seq;
      len_q   <= in_len;
      new_end <= {1'b0, in_seq} + (SEQ_W+1)'(in_len);
    end
    if (cmd.prev_load) begin
      prev_end <= rd_end;
    end
    if (cmd.set_status) begin
      status <= cmd.status;
    end
  end

  // Segment table: one port, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[cmd.addr] <= cmd.wr_shift ? rd_data : {seq_q, len_q};
    end
    if (cmd.mem_rd) begin
      rd_data <= mem[cmd.addr];
    end
  end

  // Update count and saturating byte total
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
      bytes <= '0;
    end else if (cmd.commit) begin
      count <= count + COUNT_W'(1);
      bytes <= bytes_sum[BYTES_W] ? BYTES_MAX : bytes_sum[BYTES_W-1:0];
    end
  end

  // Flags for the controller
  always_comb begin
    sts.action  = act_q;
    sts.len_bad = (len_q > max_len);
    sts.full    = (count >= COUNT_W'(MAX_SEGMENTS));
    sts.wrap    = new_end[SEQ_W];
    sts.count   = count;
    sts.eq      = (rd_start == seq_q);
    sts.lt      = (rd_start < seq_q);
    sts.lt_over = (rd_end > {1'b0, seq_q});
    sts.gt_over = ({1'b0, rd_start} < new_end);
    sts.gap     = (prev_end != {1'b0, rd_start});
  end
endmodule

// File: rtl/tsr_ctrl.sv
// Controller: sequences the insert scan, entry shift, chain check and result.
module tsr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tsr_pkg::tsr_sts_t sts,
  output tsr_pkg::tsr_cmd_t cmd
);
  import tsr_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DECODE   = 10'b0000000010,
    S_SCAN_RD  = 10'b0000000100,
    S_SCAN_CHK = 10'b0000001000,
    S_SHIFT_RD = 10'b0000010000,
    S_SHIFT_WR = 10'b0000100000,
    S_PLACE    = 10'b0001000000,
    S_CHK_RD   = 10'b0010000000,
    S_CHK_EVAL = 10'b0100000000,
    S_OUT      = 10'b1000000000
  } state_t;

  state_t             state, state_next;
  logic [COUNT_W-1:0] idx, idx_next;
  logic [COUNT_W-1:0] pos, pos_next;
  logic [COUNT_W-1:0] idx_inc;
  logic [COUNT_W-1:0] idx_dec;
  logic               last;

  assign in_ready  = (state == S_IDLE) && !rst;
  assign out_valid = (state == S_OUT);
  assign idx_inc   = idx + COUNT_W'(1);
  assign idx_dec   = idx - COUNT_W'(1);
  assign last      = (idx_inc == sts.count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    idx <= idx_next;
    pos <= pos_next;
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    idx_next   = idx;
    pos_next   = pos;
    cmd        = '0;
    cmd.addr   = idx[SEG_ADDR_W-1:0];
    case (state)
      S_IDLE: begin
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.set_status = 1'b1;
        state_next     = S_OUT;
        idx_next       = '0;
        pos_next       = sts.count;
        case (sts.action)
          ACT_INSERT: begin
            if (sts.len_bad) begin
              cmd.status = ST_INVALID;
            end else if (sts.full) begin
              cmd.status = ST_FULL;
            end else if (sts.wrap) begin
              cmd.status = ST_WRAP;
            end else begin
              cmd.set_status = 1'b0;
              state_next     = (sts.count == '0) ? S_PLACE : S_SCAN_RD;
            end
          end
          ACT_CHECK: begin
            if (sts.count == '0) begin
              cmd.status = ST_EMPTY;
            end else begin
              cmd.set_status = 1'b0;
              state_next     = S_CHK_RD;
            end
          end
          ACT_CLEAR: begin
            cmd.clear  = 1'b1;
            cmd.status = ST_OK;
          end
          default: begin
            cmd.status = ST_OK;
          end
        endcase
      end
      S_SCAN_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts.eq) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_DUPLICATE;
          state_next     = S_OUT;
        end else if (sts.lt) begin
          if (sts.lt_over) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_OVERLAP;
            state_next     = S_OUT;
          end else if (last) begin
            state_next = S_PLACE;
          end else begin
            idx_next   = idx_inc;
            state_next = S_SCAN_RD;
          end
        end else if (sts.gt_over) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_OVERLAP;
          state_next     = S_OUT;
        end else begin
          // Open a slot at this entry: shift from the top down
          pos_next   = idx;
          idx_next   = sts.count;
          state_next = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        cmd.mem_rd = 1'b1;
        cmd.addr   = idx_dec[SEG_ADDR_W-1:0];
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.mem_we   = 1'b1;
        cmd.wr_shift = 1'b1;
        idx_next     = idx_dec;
        state_next   = (idx_dec == pos) ? S_PLACE : S_SHIFT_RD;
      end
      S_PLACE: begin
        cmd.mem_we     = 1'b1;
        cmd.addr       = pos[SEG_ADDR_W-1:0];
        cmd.commit     = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status     = ST_INSERTED;
        state_next     = S_OUT;
      end
      S_CHK_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_CHK_EVAL;
      end
      S_CHK_EVAL: begin
        cmd.prev_load = 1'b1;
        if ((idx != '0) && sts.gap) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_GAPS;
          state_next     = S_OUT;
        end else if (last) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_OK;
          state_next     = S_OUT;
        end else begin
          idx_next   = idx_inc;
          state_next = S_CHK_RD;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule

// File: rtl/tcp_segment_reorder_table.sv
// Top level of the TCP segment reorder table.
// Keeps up to 64 segments of one flow as (start, length) pairs sorted by start
// in a single-port table with registered read. One item is in work at a time:
// it is taken in the idle cycle, and its result is held until taken, after
// which the next item may enter. Clear, unused actions and inserts rejected
// on length, fullness or wrap go from acceptance through decode to the result.
// An insert reads and compares each held entry scanned (up to the first start
// above the new one), then reads and writes each entry moved up to open its
// slot, then places the new entry; a check reads and evaluates each entry
// walked. The single table port allows one access per cycle.
// max_segment_len sits at byte address 0 of the configuration port.
module tcp_segment_reorder_table (
  input  logic                          clk,
  input  logic                          rst,
  tsr_req_if.sink                       seg_in,
  tsr_res_if.source                     res_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tsr_pkg::PADDR_W-1:0]   paddr,
  input  logic [tsr_pkg::PDATA_W-1:0]   pwdata,
  output logic [tsr_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import tsr_pkg::*;

  tsr_cmd_t            cmd;
  tsr_sts_t            sts;
  logic [LEN_W-1:0]    max_len;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;
  logic [BYTES_W-1:0]  bytes;

  tsr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_len (max_len)
  );

  tsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (seg_in.valid),
    .in_ready  (seg_in.ready),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tsr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_action (seg_in.action),
    .in_seq    (seg_in.seq_start),
    .in_len    (seg_in.seg_length),
    .max_len   (max_len),
    .status    (status),
    .count     (count),
    .bytes     (bytes)
  );

  // Drive the result item
  assign res_out.status        = status;
  assign res_out.segment_count = OUT_COUNT_W'(count);
  assign res_out.byte_total    = bytes;
endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the TCP segment reorder table: segment requests in, status out.
module tb_top;
  import tsr_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED   = 2'd3;
  localparam logic [PADDR_W-1:0]  MAX_LEN_ADDR = {REG_MAX_LEN, 2'b00};
  localparam int unsigned         CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned         PHASE_ITEMS  = 335;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [OUT_COUNT_W-1:0] segment_count;
    logic [BYTES_W-1:0]     byte_total;
  } seg_status_t;

  // Track the held segments of the flow and the status each request must return
  class seg_table_tracker;
    logic [SEQ_W-1:0]   held_start [MAX_SEGMENTS];
    logic [LEN_W-1:0]   held_len [MAX_SEGMENTS];
    int                 held_count;
    logic [BYTES_W-1:0] held_bytes;
    logic [LEN_W-1:0]   max_len;
    seg_status_t        due_status [$];
    int unsigned        mismatches;

    function new();
      held_count = 0;
      held_bytes = '0;
      max_len    = RESET_MAX_LEN;
      mismatches = 0;
    endfunction

    // Place a segment in sorted position, or name the reason it is refused
    function logic [STATUS_W-1:0] try_insert(logic [SEQ_W-1:0] seq, logic [LEN_W-1:0] len);
      logic [SEQ_W:0]   new_end;
      logic [SEQ_W:0]   old_end;
      logic [BYTES_W:0] sum;
      int               pos;
      int               i;
      new_end = {1'b0, seq} + (SEQ_W+1)'(len);
      if (len > max_len) return ST_INVALID;
      if (held_count >= MAX_SEGMENTS) return ST_FULL;
      if (new_end[SEQ_W]) return ST_WRAP;
      pos = held_count;
      for (i = 0; i < held_count; i++) begin
        if (held_start[i] == seq) return ST_DUPLICATE;
        if (held_start[i] < seq) begin
          old_end = {1'b0, held_start[i]} + (SEQ_W+1)'(held_len[i]);
          if (old_end > {1'b0, seq}) return ST_OVERLAP;
        end else begin
          if ({1'b0, held_start[i]} < new_end) return ST_OVERLAP;
          pos = i;
          break;
        end
      end
      // Open the slot by moving later entries up one place
      for (i = held_count; i > pos; i--) begin
        held_start[i] = held_start[i-1];
        held_len[i]   = held_len[i-1];
      end
      held_start[pos] = seq;
      held_len[pos]   = len;
      held_count++;
      sum        = {1'b0, held_bytes} + (BYTES_W+1)'(len);
      held_bytes = sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];
      return ST_INSERTED;
    endfunction

    // Walk adjacent entries and flag the first hole or overlap
    function logic [STATUS_W-1:0] walk_chain();
      logic [SEQ_W:0] seg_end;
      int             i;
      if (held_count == 0) return ST_EMPTY;
      for (i = 0; i + 1 < held_count; i++) begin
        seg_end = {1'b0, held_start[i]} + (SEQ_W+1)'(held_len[i]);
        if (seg_end != {1'b0, held_start[i+1]}) return ST_GAPS;
      end
      return ST_OK;
    endfunction

    function void note_request(logic [ACTION_W-1:0] act, logic [SEQ_W-1:0] seq,
                               logic [LEN_W-1:0] len);
      seg_status_t want;
      case (act)
        ACT_INSERT: want.status = try_insert(seq, len);
        ACT_CHECK:  want.status = walk_chain();
        ACT_CLEAR: begin
          held_count  = 0;
          held_bytes  = '0;
          want.status = ST_OK;
        end
        default:    want.status = ST_OK;
      endcase
      want.segment_count = OUT_COUNT_W'(held_count);
      want.byte_total    = held_bytes;
      due_status.push_back(want);
    endfunction

    function void check_status(seg_status_t got);
      seg_status_t want;
      if (due_status.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item: status %0d count %0d bytes %0d", $time,
                 got.status, got.segment_count, got.byte_total);
        return;
      end
      want = due_status.pop_front();
      if (got.status !== want.status) begin
        mismatches++;
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
      end
      if (got.segment_count !== want.segment_count) begin
        mismatches++;
        $display("%0t: segment_count expected %0d got %0d", $time,
                 want.segment_count, got.segment_count);
      end
      if (got.byte_total !== want.byte_total) begin
        mismatches++;
        $display("%0t: byte_total expected %0d got %0d", $time,
                 want.byte_total, got.byte_total);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  tsr_req_if seg_if ();
  tsr_res_if res_if ();

  seg_table_tracker tracker = new();

  bit          offering;
  int unsigned items_sent;
  int unsigned send_burst;
  int unsigned cycle_count;
  int unsigned stall_left;
  int unsigned free_left;
  int unsigned results_taken;
  bit          long_hold_done;

  tcp_segment_reorder_table DUT (
    .clk     (clk),
    .rst     (rst),
    .seg_in  (seg_if),
    .res_out (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tcp_segment_reorder_table regression: fail");
      $finish;
    end
  end

  // Take status items, with random stalls and one long hold-off
  initial begin
    res_if.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready) begin
        tracker.check_status({res_if.status, res_if.segment_count, res_if.byte_total});
        results_taken++;
      end
      if (!long_hold_done && results_taken >= 500) begin
        long_hold_done = 1;
        stall_left     = 400;
        free_left      = 0;
      end
      if (stall_left == 0 && free_left == 0) begin
        case ($urandom_range(0, 19))
          0, 1:          free_left  = $urandom_range(20, 80);
          2, 3, 4, 5, 6: stall_left = $urandom_range(1, 3);
          7:             stall_left = $urandom_range(10, 40);
          default:       ;
        endcase
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        if (free_left > 0) free_left--;
        res_if.ready <= 1'b1;
      end
    end
  end

  // Lower valid once if an item is still on offer
  task automatic drop_valid();
    if (offering) begin
      seg_if.valid <= 1'b0;
      offering = 0;
    end
  endtask

  // Pause the sender: mostly short gaps, some long, some stretches with none
  task automatic sender_gap();
    int unsigned gap;
    gap = 0;
    if (send_burst > 0) begin
      send_burst--;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:44]:  gap = 0;
        [45:52]: send_burst = $urandom_range(10, 40);
        [53:89]: gap = $urandom_range(1, 3);
        [90:96]: gap = $urandom_range(4, 10);
        default: gap = $urandom_range(20, 50);
      endcase
    end
    if (gap > 0) begin
      drop_valid();
      repeat (gap) @(posedge clk);
    end
  endtask

  // Offer one request, hold it until taken, then note it
  task automatic send_item(logic [ACTION_W-1:0] act, logic [SEQ_W-1:0] seq,
                           logic [LEN_W-1:0] len);
    seg_if.valid      <= 1'b1;
    seg_if.action     <= act;
    seg_if.seq_start  <= seq;
    seg_if.seg_length <= len;
    offering = 1;
    do @(posedge clk); while (!seg_if.ready);
    tracker.note_request(act, seq, len);
    if (act != ACT_UNUSED) items_sent++;
    sender_gap();
  endtask

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read_check(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] want);
    logic [PDATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      tracker.mismatches++;
      $display("%0t: max_segment_len read expected %0d got %0d", $time, want, got);
    end
  endtask

  // Drain every outstanding status, then change the length limit
  task automatic set_max_len(logic [LEN_W-1:0] value);
    drop_valid();
    while (tracker.due_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    apb_write(MAX_LEN_ADDR, PDATA_W'(value));
    tracker.max_len = value;
    @(posedge clk);
    apb_read_check(MAX_LEN_ADDR, PDATA_W'(value));
  endtask

  // Length mostly small and legal, sometimes at or just past the limit
  function automatic logic [LEN_W-1:0] pick_len();
    int unsigned cap;
    cap = (tracker.max_len < 300) ? tracker.max_len : 300;
    case ($urandom_range(0, 99)) inside
      [0:69]:  return LEN_W'($urandom_range(0, cap));
      [70:84]: return LEN_W'($urandom_range(0, tracker.max_len));
      [85:89]: return tracker.max_len;
      [90:94]: return (tracker.max_len == '1) ? tracker.max_len : tracker.max_len + 1'b1;
      default: return LEN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Insert a run of mostly back-to-back segments, sometimes with holes, in shuffled order, then check it
  task automatic run_chain();
    logic [SEQ_W-1:0] starts [12];
    logic [LEN_W-1:0] lens [12];
    int               order [12];
    logic [SEQ_W-1:0] cur;
    int               k;
    int               j;
    int               m;
    int               tmp;
    if ($urandom_range(0, 2) == 0) send_item(ACT_CLEAR, $urandom, LEN_W'($urandom));
    k = $urandom_range(1, 12);
    case ($urandom_range(0, 9))
      0:       cur = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      1:       cur = $urandom_range(0, 1000);
      default: cur = $urandom;
    endcase
    for (j = 0; j < k; j++) begin
      lens[j]   = pick_len();
      starts[j] = cur;
      order[j]  = j;
      cur       = cur + lens[j];
      if ($urandom_range(0, 4) == 0) cur = cur + $urandom_range(1, 50);
    end
    for (j = k - 1; j > 0; j--) begin
      m        = $urandom_range(0, j);
      tmp      = order[j];
      order[j] = order[m];
      order[m] = tmp;
    end
    for (j = 0; j < k; j++) send_item(ACT_INSERT, starts[order[j]], lens[order[j]]);
    send_item(ACT_CHECK, $urandom, LEN_W'($urandom));
  endtask

  // Aim inserts at held entries: same start, inside, just before, at the end
  task automatic run_probe();
    logic [SEQ_W-1:0] s;
    logic [SEQ_W-1:0] p;
    logic [LEN_W-1:0] l;
    logic [LEN_W-1:0] plen;
    int               n;
    int               j;
    int               idx;
    n = $urandom_range(1, 3);
    for (j = 0; j < n; j++) begin
      if (tracker.held_count == 0) begin
        send_item(ACT_INSERT, $urandom, pick_len());
        continue;
      end
      idx  = $urandom_range(0, tracker.held_count - 1);
      s    = tracker.held_start[idx];
      l    = tracker.held_len[idx];
      plen = pick_len();
      case ($urandom_range(0, 4))
        0: p = s;
        1: p = s + ((l > 1) ? $urandom_range(1, l - 1) : 0);
        2: begin
          p    = s - 1;
          plen = LEN_W'($urandom_range(2, 10));
        end
        3: p = s + l;
        default: p = s + $urandom_range(0, 2 * l + 10);
      endcase
      send_item(ACT_INSERT, p, plen);
    end
  endtask

  // Fill the table to capacity and push past it
  task automatic run_fill();
    logic [SEQ_W-1:0] cur;
    logic [LEN_W-1:0] l;
    int unsigned      cap;
    int               j;
    send_item(ACT_CLEAR, $urandom, LEN_W'($urandom));
    cap = (tracker.max_len < 20) ? tracker.max_len : 20;
    cur = $urandom_range(0, 100000);
    for (j = 0; j < MAX_SEGMENTS + 2; j++) begin
      l = LEN_W'($urandom_range(0, cap));
      send_item(ACT_INSERT, cur, l);
      cur = cur + l + ((l == 0) ? 1 : 0) + (($urandom_range(0, 7) == 0) ? 5 : 0);
    end
    send_item(ACT_INSERT, 32'hFFFF_FFFF, LEN_W'(2));
    send_item(ACT_CHECK, $urandom, LEN_W'($urandom));
  endtask

  task automatic run_phase(int unsigned quota);
    int unsigned target;
    int          n;
    target = items_sent + quota;
    while (items_sent < target) begin
      case ($urandom_range(0, 99)) inside
        [0:39]:  run_chain();
        [40:69]: run_probe();
        [70:71]: run_fill();
        [72:87]: begin
          for (n = $urandom_range(1, 3); n > 0; n--)
            send_item(ACT_INSERT + ACTION_W'($urandom_range(0, 3)), $urandom,
                      LEN_W'($urandom_range(0, 65535)));
        end
        [88:94]: send_item(ACT_CHECK, $urandom, LEN_W'($urandom));
        default: send_item(ACT_CLEAR, $urandom, LEN_W'($urandom));
      endcase
    end
  endtask

  initial begin
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    seg_if.valid      <= 1'b0;
    seg_if.action     <= ACT_INSERT;
    seg_if.seq_start  <= '0;
    seg_if.seg_length <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset limit, edges of the table and of the sequence space
    apb_read_check(MAX_LEN_ADDR, PDATA_W'(RESET_MAX_LEN));
    send_item(ACT_CHECK,  $urandom, LEN_W'($urandom));
    send_item(ACT_INSERT, 32'd0, LEN_W'(64001));
    send_item(ACT_INSERT, 32'd0, LEN_W'(64000));
    send_item(ACT_CHECK,  $urandom, LEN_W'($urandom));
    send_item(ACT_INSERT, 32'd0, LEN_W'(5));
    send_item(ACT_INSERT, 32'd100, LEN_W'(1));
    send_item(ACT_INSERT, 32'd64000, LEN_W'(0));
    send_item(ACT_CHECK,  $urandom, LEN_W'($urandom));
    send_item(ACT_INSERT, 32'd70000, LEN_W'(10));
    send_item(ACT_CHECK,  $urandom, LEN_W'($urandom));
    send_item(ACT_INSERT, 32'd69995, LEN_W'(10));
    send_item(ACT_INSERT, 32'hFFFF_FFFF, LEN_W'(64001));
    send_item(ACT_INSERT, 32'hFFFF_FFFF, LEN_W'(1));
    send_item(ACT_INSERT, 32'hFFFF_FFFF, LEN_W'(0));
    send_item(ACT_UNUSED, $urandom, LEN_W'($urandom));
    send_item(ACT_CLEAR,  $urandom, LEN_W'($urandom));
    send_item(ACT_CHECK,  $urandom, LEN_W'($urandom));

    // Directed: widest limit, full-length segments at both ends
    set_max_len(16'hFFFF);
    send_item(ACT_INSERT, 32'hFFFF_0000, 16'hFFFF);
    send_item(ACT_INSERT, 32'd0, 16'hFFFF);
    send_item(ACT_INSERT, 32'h0000_FFFF, LEN_W'(0));
    send_item(ACT_CHECK,  $urandom, LEN_W'($urandom));

    // Directed: narrowest limit
    set_max_len(LEN_W'(1));
    send_item(ACT_INSERT, 32'd5, LEN_W'(2));
    send_item(ACT_INSERT, 32'd5, LEN_W'(1));
    send_item(ACT_INSERT, 32'd6, LEN_W'(0));
    send_item(ACT_CLEAR,  $urandom, LEN_W'($urandom));

    // Random phases across several limits
    set_max_len(16'hFFFF);
    run_phase(PHASE_ITEMS);
    set_max_len(LEN_W'(4000));
    run_phase(PHASE_ITEMS);
    set_max_len(LEN_W'(1));
    run_phase(PHASE_ITEMS);
    set_max_len(RESET_MAX_LEN);
    run_phase(PHASE_ITEMS);
    set_max_len(LEN_W'($urandom_range(2, 65534)));
    run_phase(PHASE_ITEMS);

    // Drain and let any stray item show up
    drop_valid();
    while (tracker.due_status.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("tcp_segment_reorder_table regression: pass");
    end else begin
      $display("tcp_segment_reorder_table regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tsr_pkg.sv
rtl/tsr_if.sv
rtl/tsr_regs.sv
rtl/tsr_dp.sv
rtl/tsr_ctrl.sv
rtl/tcp_segment_reorder_table.sv
sim/tb_top.sv
